// File: src/upp_pkg.sv
package upp_pkg;

   // character codes
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS      = 8'h2b;
   localparam logic [7:0] CHAR_AMP       = 8'h26;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3d;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // status codes
   localparam logic [1:0] STATUS_PARSING = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   // percent escape tracking
   typedef enum logic [2:0] {
      ESC_IDLE    = 3'b001,
      ESC_WAIT_HI = 3'b010,
      ESC_WAIT_LO = 3'b100
   } esc_type;

   typedef struct packed {
      logic       in_value_part;
      esc_type    esc;
      logic [3:0] high_nibble;
      logic       seen_text;
      logic       failed;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      in_value_part: 1'b0,
      esc:           ESC_IDLE,
      high_nibble:   4'd0,
      seen_text:     1'b0,
      failed:        1'b0
   };

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       in_value;
      logic       name_done;
      logic       pair_done;
      logic [1:0] status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // hex digit decode, either case
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.ok    = 1'b0;
      d.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.ok    = 1'b1;
         d.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         d.ok    = 1'b1;
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

// File: src/upp_core.sv
module upp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          ch,
   input  logic                end_of_text,
   output upp_pkg::result_type result
);
   import upp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   hex_digit_type   digit;
   logic            err;

   assign digit = hex_decode(ch);

   always_comb begin
      state_in = state_ff;
      result   = '0;
      err      = 1'b0;
      if (end_of_text) begin
         if (state_ff.failed) begin
            result.status = STATUS_ERROR;
         end else if (!state_ff.seen_text) begin
            result.status = STATUS_DONE;
         end else if (state_ff.esc == ESC_WAIT_HI || state_ff.esc == ESC_WAIT_LO ||
                      !state_ff.in_value_part) begin
            result.status = STATUS_ERROR;
         end else begin
            result.pair_done = 1'b1;
            result.status    = STATUS_DONE;
         end
         state_in = PARSE_STATE_RESET;
      end else if (!state_ff.failed) begin
         state_in.seen_text = 1'b1;
         if (state_ff.esc == ESC_WAIT_HI || state_ff.esc == ESC_WAIT_LO) begin
            if (!digit.ok) begin
               err = 1'b1;
            end else if (state_ff.esc == ESC_WAIT_HI) begin
               state_in.high_nibble = digit.value;
               state_in.esc         = ESC_WAIT_LO;
            end else begin
               result.has_byte      = 1'b1;
               result.out_byte      = {state_ff.high_nibble, digit.value};
               result.in_value      = state_ff.in_value_part;
               state_in.esc         = ESC_IDLE;
               state_in.high_nibble = 4'd0;
            end
         end else begin
            state_in.esc = ESC_IDLE;
            case (ch)
               CHAR_AMP, CHAR_SEMICOLON: begin
                  if (!state_ff.in_value_part) begin
                     err = 1'b1;
                  end else begin
                     result.pair_done       = 1'b1;
                     state_in.in_value_part = 1'b0;
                  end
               end
               CHAR_EQUALS: begin
                  if (state_ff.in_value_part) begin
                     err = 1'b1;
                  end else begin
                     result.name_done       = 1'b1;
                     state_in.in_value_part = 1'b1;
                  end
               end
               CHAR_PERCENT: begin
                  state_in.esc = ESC_WAIT_HI;
               end
               default: begin
                  result.has_byte = 1'b1;
                  result.out_byte = (ch == CHAR_PLUS) ? CHAR_SPACE : ch;
                  result.in_value = state_ff.in_value_part;
               end
            endcase
         end
         if (err) begin
            state_in.failed = 1'b1;
            result          = '0;
            result.status   = STATUS_ERROR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/urlencoded_pair_parser.sv
// form-urlencoded pair parser
// req channel: one text character per word (req_ch), or an end marker word
// with req_end_of_text set, whose character is ignored
// rsp channel: exactly one result word per request word, in order; it holds
// a decoded name or value byte, the name-ended and pair-ended marks, and a
// status (parsing, finished, error)
// path: a request word is held in the input register, is parsed there and
// moves into the result register once that slot is free; rsp_valid then
// rises and the result can be taken
// throughput: one word per cycle while rsp_ready stays high; the parser state update is a single
// short decode between the input register and the result register
// reset: synchronous, active high; clears both register valids and returns
// the parser to the start of a new text
// stall: while rsp_ready is low the result register holds; the input
// register still takes one more word, after that req_ready drops
module urlencoded_pair_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_in_value,
   output logic       rsp_name_done,
   output logic       rsp_pair_done,
   output logic [1:0] rsp_status
);
   import upp_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_eot_ff;

   // result register
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   logic advance;

   // move the held word into the result register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // parser state lives in the core and steps only when a word moves on
   upp_core core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .ch          (in_ch_ff),
      .end_of_text (in_eot_ff),
      .result      (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_eot_ff <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_has_byte  = out_ff.has_byte;
   assign rsp_out_byte  = out_ff.out_byte;
   assign rsp_in_value  = out_ff.in_value;
   assign rsp_name_done = out_ff.name_done;
   assign rsp_pair_done = out_ff.pair_done;
   assign rsp_status    = out_ff.status;

endmodule

// File: tb/sv/upp_tb_pkg.sv
`timescale 1ns / 100ps

package upp_tb_pkg;

   import upp_pkg::*;

   class parse_scoreboard;

      // mirror of the parser state
      logic       value_part;
      esc_type    esc;
      logic [3:0] hi_nibble;
      logic       seen_text;
      logic       failed;

      result_type parse_results_due[$];
      int         fails;
      int         live_words;

      function new();
         fails      = 0;
         live_words = 0;
         restart_text();
      endfunction

      function void restart_text();
         value_part = 1'b0;
         esc        = ESC_IDLE;
         hi_nibble  = 4'd0;
         seen_text  = 1'b0;
         failed     = 1'b0;
      endfunction

      // hex digit value, -1 when not a digit
      function int hex_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
         if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
         if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
         return -1;
      endfunction

      function int pending();
         return parse_results_due.size();
      endfunction

      // parse one accepted request word and queue the result it must give
      function void parse_char(logic [7:0] ch, logic eot);
         result_type r;
         int         h;
         logic       err;
         r   = '0;
         err = 1'b0;
         if (!failed || eot) live_words++;
         if (eot) begin
            if (failed) r.status = STATUS_ERROR;
            else if (!seen_text) r.status = STATUS_DONE;
            else if (esc != ESC_IDLE || !value_part) r.status = STATUS_ERROR;
            else begin
               r.pair_done = 1'b1;
               r.status    = STATUS_DONE;
            end
            restart_text();
         end else if (!failed) begin
            seen_text = 1'b1;
            if (esc != ESC_IDLE) begin
               h = hex_value(ch);
               if (h < 0) begin
                  err = 1'b1;
               end else if (esc == ESC_WAIT_HI) begin
                  hi_nibble = h[3:0];
                  esc       = ESC_WAIT_LO;
               end else begin
                  r.has_byte = 1'b1;
                  r.out_byte = {hi_nibble, h[3:0]};
                  r.in_value = value_part;
                  esc        = ESC_IDLE;
                  hi_nibble  = 4'd0;
               end
            end else if (ch == CHAR_AMP || ch == CHAR_SEMICOLON) begin
               if (!value_part) err = 1'b1;
               else begin
                  r.pair_done = 1'b1;
                  value_part  = 1'b0;
               end
            end else if (ch == CHAR_EQUALS) begin
               if (value_part) err = 1'b1;
               else begin
                  r.name_done = 1'b1;
                  value_part  = 1'b1;
               end
            end else if (ch == CHAR_PERCENT) begin
               esc = ESC_WAIT_HI;
            end else begin
               r.has_byte = 1'b1;
               r.out_byte = (ch == CHAR_PLUS) ? CHAR_SPACE : ch;
               r.in_value = value_part;
            end
            if (err) begin
               failed   = 1'b1;
               r        = '0;
               r.status = STATUS_ERROR;
            end
         end
         parse_results_due.push_back(r);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fails++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (parse_results_due.size() == 0) begin
            $error("result word with nothing expected: 0x%0h", got);
            fails++;
            return;
         end
         want = parse_results_due.pop_front();
         compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("in_value", 8'(want.in_value), 8'(got.in_value));
         compare_field("name_done", 8'(want.name_done), 8'(got.name_done));
         compare_field("pair_done", 8'(want.pair_done), 8'(got.pair_done));
         compare_field("status", 8'(want.status), 8'(got.status));
      endfunction

   endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   import upp_pkg::*;
   import upp_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_WORDS = 1250;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 8;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch          = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic       rsp_has_byte;
   logic [7:0] rsp_out_byte;
   logic       rsp_in_value;
   logic       rsp_name_done;
   logic       rsp_pair_done;
   logic [1:0] rsp_status;

   result_type      rsp_word;
   parse_scoreboard sb;

   int cycle_count = 0;
   int words_sent  = 0;
   int send_burst  = 0;
   bit hold_rsp    = 1'b0;

   urlencoded_pair_parser u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_in_value    (rsp_in_value),
      .rsp_name_done   (rsp_name_done),
      .rsp_pair_done   (rsp_pair_done),
      .rsp_status      (rsp_status)
   );

   // field order matches result_type
   assign rsp_word = {rsp_has_byte, rsp_out_byte, rsp_in_value,
                      rsp_name_done, rsp_pair_done, rsp_status};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // both handshakes are sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.parse_char(req_ch, req_end_of_text);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_word);
      end
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // result side: random stalls, stall-free bursts, and the long hold on request
   initial begin
      int burst_left;
      int gap;
      burst_left = 0;
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (burst_left > 0) begin
            rsp_ready <= 1'b1;
            burst_left--;
            @(posedge clock);
         end else begin
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 100);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one word, hold it until taken, then maybe idle
   task automatic send_word(input logic [7:0] ch, input logic eot);
      int gap;
      req_valid       <= 1'b1;
      req_ch          <= ch;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (send_burst > 0) begin
         send_burst--;
      end else begin
         if ($urandom_range(0, 19) == 0) send_burst = $urandom_range(20, 100);
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_ch    <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // end marker, character is don't-care so randomize it
   task automatic send_eot();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // stop offering and wait until every result word is back
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(32'h30 + v);
      if ($urandom_range(0, 1) == 1) return 8'(32'h61 + v - 10);
      return 8'(32'h41 + v - 10);
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 4))
         0: return CHAR_PERCENT;
         1: return CHAR_AMP;
         2: return CHAR_SEMICOLON;
         3: return CHAR_EQUALS;
         default: return CHAR_PLUS;
      endcase
   endfunction

   // any byte except the delimiters, plus gets extra weight
   task automatic send_plain();
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         c = CHAR_PLUS;
      end else begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_PERCENT || c == CHAR_AMP ||
                c == CHAR_SEMICOLON || c == CHAR_EQUALS);
      end
      send_word(c, 1'b0);
   endtask

   // one decoded byte: plain character or a full percent escape
   task automatic send_token();
      if ($urandom_range(0, 9) < 7) begin
         send_plain();
      end else begin
         send_word(CHAR_PERCENT, 1'b0);
         send_word(hex_char(), 1'b0);
         send_word(hex_char(), 1'b0);
      end
   endtask

   task automatic send_pair();
      repeat ($urandom_range(0, 4)) send_token();
      send_word(CHAR_EQUALS, 1'b0);
      repeat ($urandom_range(0, 4)) send_token();
   endtask

   task automatic send_well_formed();
      int n;
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         if (i > 0) send_word(($urandom_range(0, 1) == 1) ? CHAR_AMP : CHAR_SEMICOLON, 1'b0);
         send_pair();
      end
      send_eot();
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 3))
         0: begin
            // stray special character somewhere after a good pair
            send_pair();
            send_word(special_char(), 1'b0);
            repeat ($urandom_range(0, 4)) send_token();
         end
         1: begin
            // raw noise, heavy on delimiters and hex digits
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: send_word(special_char(), 1'b0);
                  1: send_word(hex_char(), 1'b0);
                  default: send_word(8'($urandom_range(0, 255)), 1'b0);
               endcase
            end
         end
         2: begin
            // escape cut off by the end marker
            send_pair();
            send_word(CHAR_PERCENT, 1'b0);
            if ($urandom_range(0, 1) == 1) send_word(hex_char(), 1'b0);
         end
         default: begin
            // text ends inside a name
            if ($urandom_range(0, 1) == 1) begin
               send_pair();
               send_word(CHAR_AMP, 1'b0);
            end
            repeat ($urandom_range(0, 3)) send_token();
         end
      endcase
      send_eot();
   endtask

   initial begin
      int live_start;
      int text_count;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty text
      send_eot();
      // escapes at both extremes, plus, zero and 0xff bytes, then end right after a separator
      send_text("%00+=");
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b0);
      send_text("%Ff;");
      send_eot();
      // separator in a name, following word ignored
      send_text("&x");
      send_eot();
      // equals inside a value
      send_text("==");
      send_eot();
      // escape cut off at the end
      send_text("=%4");
      send_eot();
      // bad escape digit
      send_text("%%");
      send_eot();
      // clean finish inside a value
      send_text("=v");
      send_eot();

      live_start = sb.live_words;
      text_count = 0;
      while (sb.live_words - live_start < RANDOM_WORDS) begin
         text_count++;
         // long result stall while words keep coming, so the input backs up
         if (text_count == 15 || text_count == 150) hold_rsp = 1'b1;
         // one full pause with nothing in flight
         if (text_count == 80) drain_all();
         if ($urandom_range(0, 99) < 85) send_well_formed();
         else send_broken();
      end

      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) $error("%0d result words never arrived", sb.pending());
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/upp_pkg.sv
src/upp_core.sv
src/urlencoded_pair_parser.sv
tb/sv/upp_tb_pkg.sv
tb/sv/tb_top.sv
